/* design/lmsd_pkg.sv */
// Shared types and codes of the LED matrix scan driver.
`default_nettype none

package lmsd_pkg;

	// Input command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [3:0] BRIGHT_RESET = 4'd10;

	typedef struct packed {
		logic [1:0]        command;
		logic signed [7:0] pos_x;
		logic signed [7:0] pos_y;
		logic [11:0]       pixel_color;
	} in_item_t;

	typedef struct packed {
		logic       event_kind;
		logic       upper_red;
		logic       upper_green;
		logic       upper_blue;
		logic       lower_red;
		logic       lower_green;
		logic       lower_blue;
		logic [3:0] row_address;
		logic [5:0] column_index;
		logic       latch;
		logic       panel_on;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_TICK,
		OP_CLEAR
	} op_kind_t;

	// One classified command waiting for the back end
	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [11:0] colour;
		logic [3:0]  bright;
	} op_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_SHIFT,
		BK_SHIFT_END,
		BK_ENABLE
	} back_state_t;

endpackage

`default_nettype wire

/* design/lmsd_front.sv */
// Front end: input handshake, brightness register and command classification.
`default_nettype none

module lmsd_front import lmsd_pkg::*; #(
	parameter int PANEL_COLUMNS = 64,
	parameter int PANEL_ROWS    = 32,
	parameter int LOOP_STEPS    = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic     cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic     init_busy,
	input  wire logic     q_full,
	output logic          q_push,
	output op_t           q_data
);

	logic [3:0] brightness_q;
	logic [3:0] bright_clamped;
	logic       x_ok;
	logic       y_ok;
	logic       push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RESET;
		end else if (cfg_we) begin
			brightness_q <= cfg_wdata;
		end
	end

	assign bright_clamped = (5'(brightness_q) > 5'(LOOP_STEPS)) ? 4'(LOOP_STEPS) : brightness_q;

	assign x_ok = !in_data.pos_x[7] && ({2'b00, in_data.pos_x[6:0]} < 9'(PANEL_COLUMNS));
	assign y_ok = !in_data.pos_y[7] && ({2'b00, in_data.pos_y[6:0]} < 9'(PANEL_ROWS));

	assign in_ready = !q_full && !init_busy;

	always_comb begin
		q_data.kind   = OP_WRITE;
		q_data.x      = in_data.pos_x;
		q_data.y      = in_data.pos_y;
		q_data.colour = in_data.pixel_color;
		q_data.bright = bright_clamped;
		push_ok       = 1'b0;
		case (in_data.command)
			CMD_WRITE: begin
				q_data.kind = OP_WRITE;
				push_ok     = x_ok && y_ok;
			end
			CMD_TICK: begin
				q_data.kind = OP_TICK;
				push_ok     = 1'b1;
			end
			CMD_CLEAR: begin
				q_data.kind = OP_CLEAR;
				push_ok     = 1'b1;
			end
			// drop the undefined code
			default: push_ok = 1'b0;
		endcase
	end

	assign q_push = in_valid && in_ready && push_ok;

endmodule

`default_nettype wire

/* design/lmsd_queue.sv */
// Two-entry command queue between front and back end.
`default_nettype none

module lmsd_queue import lmsd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_data,
	output logic      full,
	input  wire logic pop,
	output op_t       pop_data,
	output logic      empty
);

	op_t        slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/lmsd_back.sv */
// Back end: frame store, clearing sweep, scan sequencer and output register.
`default_nettype none

module lmsd_back import lmsd_pkg::*; #(
	parameter int PANEL_COLUMNS = 64,
	parameter int PANEL_ROWS    = 32,
	parameter int LOOP_STEPS    = 10,
	parameter int LAYER_COUNT   = 256,
	parameter int LAYER_STEP    = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire op_t  op,
	input  wire logic q_empty,
	output logic      q_pop,
	output logic      init_busy,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data
);

	localparam int HALF   = PANEL_ROWS / 2;
	localparam int STORE  = PANEL_ROWS * PANEL_COLUMNS;
	localparam int ADDR_W = $clog2(STORE);
	localparam int COL_W  = $clog2(PANEL_COLUMNS);
	localparam int ROW_W  = (HALF > 1) ? $clog2(HALF) : 1;
	localparam int STEP_W = $clog2(LOOP_STEPS);

	function automatic logic layer_bit(input logic [3:0] nib, input logic [7:0] thr);
		return {nib, 4'b0000} > thr;
	endfunction

	logic [11:0] mem [STORE];

	back_state_t       state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ROW_W-1:0]  row_q;
	logic [7:0]        thr_q;
	logic [STEP_W-1:0] step_q;
	logic [COL_W-1:0]  col_q;
	logic              latch_on_q;
	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic              last_s1;
	logic [11:0]       up_q;
	logic [11:0]       lo_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              out_free;
	logic              s1_move;
	logic              issue;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] addr_up;
	logic [ADDR_W-1:0] addr_lo;
	logic              tick_pop;
	logic              start_shift;
	logic              enable_now;
	logic              load_enable;
	logic              row_done;
	logic              has_on;
	logic [4:0]        on_step;
	logic              clr_last;
	logic              row_wrap;
	logic [8:0]        thr_sum;
	logic [7:0]        thr_next;

	assign out_free = !out_valid_q || out_ready;
	assign s1_move  = valid_s1 && out_free;
	assign issue    = (state_q == BK_SHIFT) && (!valid_s1 || s1_move);
	assign clr_last = (clr_addr_q == ADDR_W'(STORE - 1));

	assign has_on     = (op.bright != 4'd0);
	assign on_step    = 5'(LOOP_STEPS) - {1'b0, op.bright};
	assign enable_now = has_on && (5'(step_q) == on_step);

	assign addr_up = ADDR_W'(row_q) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(col_q);
	assign addr_lo = addr_up + ADDR_W'(HALF * PANEL_COLUMNS);

	// next state and strobes
	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = clr_addr_q;
		tick_pop    = 1'b0;
		start_shift = 1'b0;
		load_enable = 1'b0;
		row_done    = 1'b0;
		case (state_q)
			BK_INIT, BK_CLEAR: begin
				mem_we = 1'b1;
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (op.kind)
						OP_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = ADDR_W'(op.y) * ADDR_W'(PANEL_COLUMNS)
								+ ADDR_W'(op.x);
						end
						OP_CLEAR: state_d = BK_CLEAR;
						OP_TICK: begin
							tick_pop = 1'b1;
							if (step_q == '0) begin
								start_shift = 1'b1;
								state_d     = BK_SHIFT;
							end else if (enable_now) begin
								state_d = BK_ENABLE;
							end
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_SHIFT: begin
				if (issue && (col_q == COL_W'(PANEL_COLUMNS - 1))) begin
					state_d = BK_SHIFT_END;
				end
			end
			BK_SHIFT_END: begin
				// wait for the last column to leave the read stage
				if (!valid_s1) begin
					row_done = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			BK_ENABLE: begin
				if (out_free) begin
					load_enable = 1'b1;
					state_d     = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// frame store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= (state_q == BK_IDLE) ? op.colour : 12'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			up_q <= mem[addr_up];
			lo_q <= mem[addr_lo];
		end
	end

	// row and layer advance
	assign row_wrap = (row_q == ROW_W'(HALF - 1));
	assign thr_sum  = {1'b0, thr_q} + (row_wrap ? 9'(LAYER_STEP) : 9'd0);
	assign thr_next = (({1'b0, thr_sum} + 10'd1) >= 10'(LAYER_COUNT)) ?
		8'(LAYER_STEP - 1) : thr_sum[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			row_q       <= '0;
			thr_q       <= 8'(LAYER_STEP - 1);
			step_q      <= '0;
			col_q       <= '0;
			latch_on_q  <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mem_we && (state_q != BK_IDLE)) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + ADDR_W'(1);
			end
			if (tick_pop) begin
				step_q <= (step_q == STEP_W'(LOOP_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
			end
			if (start_shift) begin
				latch_on_q <= enable_now;
				col_q      <= '0;
			end else if (issue) begin
				col_q <= col_q + COL_W'(1);
			end
			if (row_done) begin
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
				thr_q <= thr_next;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move || load_enable) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			col_s1  <= col_q;
			last_s1 <= (col_q == COL_W'(PANEL_COLUMNS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q.event_kind   <= 1'b0;
			out_data_q.upper_red    <= layer_bit(up_q[3:0], thr_q);
			out_data_q.upper_green  <= layer_bit(up_q[7:4], thr_q);
			out_data_q.upper_blue   <= layer_bit(up_q[11:8], thr_q);
			out_data_q.lower_red    <= layer_bit(lo_q[3:0], thr_q);
			out_data_q.lower_green  <= layer_bit(lo_q[7:4], thr_q);
			out_data_q.lower_blue   <= layer_bit(lo_q[11:8], thr_q);
			out_data_q.row_address  <= 4'(row_q);
			out_data_q.column_index <= 6'(col_s1);
			out_data_q.latch        <= last_s1;
			out_data_q.panel_on     <= last_s1 && latch_on_q;
		end else if (load_enable) begin
			out_data_q.event_kind   <= 1'b1;
			out_data_q.upper_red    <= 1'b0;
			out_data_q.upper_green  <= 1'b0;
			out_data_q.upper_blue   <= 1'b0;
			out_data_q.lower_red    <= 1'b0;
			out_data_q.lower_green  <= 1'b0;
			out_data_q.lower_blue   <= 1'b0;
			out_data_q.row_address  <= 4'd0;
			out_data_q.column_index <= 6'd0;
			out_data_q.latch        <= 1'b0;
			out_data_q.panel_on     <= 1'b1;
		end
	end

	assign init_busy = (state_q == BK_INIT);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

/* design/led_matrix_scan_driver.sv */
// Top level of the LED matrix scan driver.
//
// Scan driver for a split-scan LED matrix panel. Commands enter on the input channel
// and are queued for a back end that owns the frame store. A clear command zeroes
// the store one entry a cycle, and a tick that shifts a row moves one column per
// clock while the output register is not held, set by the single pass of two frame
// store reads per column. A tick that only switches the panel on gives one panel
// enable beat. After reset the store is cleared in a pass during which in_ready
// stays low; brightness writes are taken throughout. The queue keeps accepting
// commands while the back end shifts.
`default_nettype none

module led_matrix_scan_driver import lmsd_pkg::*; #(
	parameter int PANEL_COLUMNS = 64,
	parameter int PANEL_ROWS    = 32,
	parameter int LOOP_STEPS    = 10,
	parameter int LAYER_COUNT   = 256,
	parameter int LAYER_STEP    = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata
);

	logic init_busy;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	op_t  q_in;
	op_t  q_out;

	lmsd_front #(
		.PANEL_COLUMNS(PANEL_COLUMNS),
		.PANEL_ROWS   (PANEL_ROWS),
		.LOOP_STEPS   (LOOP_STEPS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.init_busy(init_busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	lmsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.empty    (q_empty)
	);

	lmsd_back #(
		.PANEL_COLUMNS(PANEL_COLUMNS),
		.PANEL_ROWS   (PANEL_ROWS),
		.LOOP_STEPS   (LOOP_STEPS),
		.LAYER_COUNT  (LAYER_COUNT),
		.LAYER_STEP   (LAYER_STEP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (q_out),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.init_busy(init_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// no input beat during the power-up clearing pass
	a_init_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ready)
		else $error("input ready during clearing pass");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

	a_enable_beat_lit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_kind |-> out_data.panel_on && !out_data.latch)
		else $error("enable beat malformed");

	a_latch_last_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.latch |-> out_data.column_index == 6'(PANEL_COLUMNS - 1))
		else $error("latch away from last column");

endmodule

`default_nettype wire
